@@ design/bcd_long_divider_core_assert.svh @@
// Assertion macros for the BCD long divider core.
// Expects i_clk and the active-low synchronous reset i_rst_n in the including module.
`ifndef BCD_LONG_DIVIDER_CORE_ASSERT_SVH
`define BCD_LONG_DIVIDER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BLDC_ASSERT_NOW(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BLDC_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

@@ design/bcdld_pkg.sv @@
// Shared constants and a digit helper for the BCD long divider.
// No dependencies.
`default_nettype none

package bcdld_pkg;

    localparam int unsigned DIGITS_DEFAULT = 16;
    localparam int unsigned DIGIT_W        = 4;
    localparam int unsigned BCD_W          = 64;
    localparam logic [3:0]  DIGIT_MAX      = 4'd9;
    localparam logic [3:0]  DIGIT_TEN      = 4'd10;

    // Clamp a nibble above nine down to nine.
    function automatic logic [3:0] sat_digit(input logic [3:0] nib);
        sat_digit = (nib > DIGIT_MAX) ? DIGIT_MAX : nib;
    endfunction

endpackage

`default_nettype wire

@@ design/bcd_long_divider_core.sv @@
// BCD long divider core: one quotient digit per streamed dividend digit.
// Depends on bcdld_pkg and bcd_long_divider_core_assert.svh.
// Divisor channel (i_cfg_valid / o_cfg_ready / i_cfg_divisor_bcd): a beat writes
// the packed BCD divisor, least significant digit in bits 3..0. Only the low
// DIVISOR_DIGITS nibbles count; a nibble above nine acts as nine. Write it only
// while the core is idle. Reset sets the divisor to one.
// Input channel (i_in_valid / o_in_stall): one beat per dividend digit, most
// significant first; i_last_digit marks the final digit of a division.
// Output channel (o_out_valid / i_out_stall): one beat per input beat with the
// quotient digit, the running remainder, the last flag and the divide-by-zero
// flag (quotient and remainder then read zero).
// Timing: the acceptance edge shifts the digit into the work register, then one
// shared (DIVISOR_DIGITS+1)-digit BCD subtractor runs one trial per cycle until
// it borrows or q reaches nine; a zero divisor runs no trial. The quotient
// digit then goes to the result register, and only then, with the sequencer idle,
// is the next digit taken.
// Stalls: the result waits in an output register while the next digit runs; if
// the receiver still stalls when that quotient is ready, hold until it drains.
// Reset clears the running remainder, drops all valids and idles the sequencer.
`default_nettype none

module bcd_long_divider_core #(
    parameter int unsigned DIVISOR_DIGITS = bcdld_pkg::DIGITS_DEFAULT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // divisor register write
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [bcdld_pkg::BCD_W-1:0] i_cfg_divisor_bcd,
    // dividend digits in
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [3:0]                  i_dividend_digit,
    input  wire logic                        i_last_digit,
    // quotient digits out
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [3:0]                       o_quotient_digit,
    output logic [bcdld_pkg::BCD_W-1:0]      o_remainder_bcd,
    output logic                             o_is_last,
    output logic                             o_divide_by_zero
);

    localparam int unsigned ND  = DIVISOR_DIGITS;          // divisor / remainder digits
    localparam int unsigned NW  = ND + 1;                  // work register digits
    localparam int unsigned RW  = bcdld_pkg::DIGIT_W * ND; // remainder bits
    localparam int unsigned WW  = bcdld_pkg::DIGIT_W * NW; // work register bits
    localparam int unsigned BW  = bcdld_pkg::BCD_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    logic          r_state,    n_state;
    logic [RW-1:0] r_divisor,  n_divisor;   // saturated divisor digits
    logic [RW-1:0] r_part,     n_part;      // running remainder
    logic [WW-1:0] r_work,     n_work;      // shifted remainder under trial
    logic [3:0]    r_q,        n_q;         // trial count = quotient so far
    logic          r_last,     n_last;

    logic          r_out_valid, n_out_valid;
    logic [3:0]    r_out_q,     n_out_q;
    logic [BW-1:0] r_out_rem,   n_out_rem;
    logic          r_out_last,  n_out_last;
    logic          r_out_dbz,   n_out_dbz;

    // ---------------------------------------------------------------
    // Shared BCD subtractor: r_work - {0, r_divisor}
    // Borrows come from one binary add over per-digit generate/propagate.
    // ---------------------------------------------------------------
    logic [WW-1:0] sub_b;
    logic [NW-1:0] dig_gen, dig_prop;
    logic [NW:0]   cx, cy, csum, borrow;
    logic [WW-1:0] sub_diff;
    logic          sub_neg;
    logic          dv_zero;

    assign sub_b   = {{bcdld_pkg::DIGIT_W{1'b0}}, r_divisor};
    assign dv_zero = (r_divisor == '0);

    always_comb begin
        for (int i = 0; i < NW; i++) begin
            dig_gen[i]  = r_work[4*i +: 4] <  sub_b[4*i +: 4];
            dig_prop[i] = r_work[4*i +: 4] == sub_b[4*i +: 4];
        end
    end

    assign cx     = {1'b0, dig_gen};
    assign cy     = {1'b0, dig_gen | dig_prop};
    assign csum   = cx + cy;
    assign borrow = csum ^ cx ^ cy;     // borrow[i] enters digit i
    assign sub_neg = borrow[NW];

    always_comb begin
        logic [3:0] raw;
        for (int i = 0; i < NW; i++) begin
            raw = r_work[4*i +: 4] - sub_b[4*i +: 4] - {3'b000, borrow[i]};
            sub_diff[4*i +: 4] = borrow[i+1] ? raw + bcdld_pkg::DIGIT_TEN : raw;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    logic in_take, out_take, trial_ok, finish, out_free;
    logic [RW-1:0] rem_low;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_take = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign trial_ok = !dv_zero && !sub_neg && (r_q != bcdld_pkg::DIGIT_MAX);
    assign finish   = (r_state == ST_RUN) && !trial_ok && out_free;
    assign rem_low  = r_work[RW-1:0];

    always_comb begin
        n_divisor = r_divisor;
        if (i_cfg_valid && o_cfg_ready) begin
            for (int i = 0; i < ND; i++) begin
                n_divisor[4*i +: 4] = bcdld_pkg::sat_digit(i_cfg_divisor_bcd[4*i +: 4]);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_part      = r_part;
        n_work      = r_work;
        n_q         = r_q;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out_q     = r_out_q;
        n_out_rem   = r_out_rem;
        n_out_last  = r_out_last;
        n_out_dbz   = r_out_dbz;

        if (out_take) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    // shift the digit in: r = r*10 + d
                    n_work  = {r_part, bcdld_pkg::sat_digit(i_dividend_digit)};
                    n_q     = '0;
                    n_last  = i_last_digit;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (trial_ok) begin
                    // divisor still fits: take it off and count
                    n_work = sub_diff;
                    n_q    = r_q + 4'd1;
                end else if (finish) begin
                    n_out_valid = 1'b1;
                    n_out_q     = dv_zero ? 4'd0 : r_q;
                    n_out_rem   = dv_zero ? '0 : BW'(rem_low);
                    n_out_last  = r_last;
                    n_out_dbz   = dv_zero;
                    n_part      = (dv_zero || r_last) ? '0 : rem_low;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_divisor   <= RW'(1);
            r_part      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_divisor   <= n_divisor;
            r_part      <= n_part;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work     <= n_work;
        r_q        <= n_q;
        r_last     <= n_last;
        r_out_q    <= n_out_q;
        r_out_rem  <= n_out_rem;
        r_out_last <= n_out_last;
        r_out_dbz  <= n_out_dbz;
    end

    // ---------------------------------------------------------------
    // Ports
    // ---------------------------------------------------------------
    assign o_cfg_ready      = 1'b1;
    assign o_in_stall       = (r_state != ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_quotient_digit = r_out_q;
    assign o_remainder_bcd  = r_out_rem;
    assign o_is_last        = r_out_last;
    assign o_divide_by_zero = r_out_dbz;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
`include "bcd_long_divider_core_assert.svh"

    `BLDC_ASSERT_NEXT(a_take_starts_run, in_take, r_state == ST_RUN, "digit taken but no run")
    `BLDC_ASSERT_NOW(a_trial_bound, r_state == ST_RUN, r_q <= bcdld_pkg::DIGIT_MAX, "trial count past nine")
    `BLDC_ASSERT_NOW(a_dbz_zero, r_out_valid && r_out_dbz, (r_out_q == 4'd0) && (r_out_rem == '0), "zero divisor result not cleared")
    `BLDC_ASSERT_NEXT(a_hold_when_blocked, (r_state == ST_RUN) && !trial_ok && !out_free, (r_state == ST_RUN) && r_out_valid, "result dropped while output blocked")

endmodule

`default_nettype wire
